// ===== design/wtcm_pkg.sv =====
// ----------------------------------------------------------------------------
// wtcm_pkg
// Widths, codes and shared types of the wall texel coordinate mapper.
// ----------------------------------------------------------------------------
package wtcm_pkg;

   localparam int TEX_SIZE  = 64;
   localparam int FRAC_BITS = 16;
   localparam int TEX_BITS  = $clog2(TEX_SIZE);

   // field widths
   localparam int ROW_W   = 12;
   localparam int DIR_W   = 19;
   localparam int POS_W   = 24;
   localparam int DIST_W  = 24;
   localparam int CELL_W  = 8;
   localparam int SLICE_W = 16;

   // hit = (pos << F) + dist * dir - (cell << 2F), all exact
   localparam int POS_SH_W  = POS_W + FRAC_BITS;
   localparam int CELL_SH_W = CELL_W + 2 * FRAC_BITS;
   localparam int BASE_W    = ((POS_SH_W > CELL_SH_W) ? POS_SH_W : CELL_SH_W) + 1;
   localparam int PROD_W    = DIST_W + DIR_W;
   localparam int HIT_W     = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 1;
   localparam int COL_SHIFT = 2 * FRAC_BITS - TEX_BITS;

   // texel row: (row - mid + slice/2) * TEX_SIZE / slice
   localparam int NUM_W     = SLICE_W + 2;
   localparam int MAG_W     = NUM_W - 1;
   localparam int DVD_W     = MAG_W + TEX_BITS;
   localparam int DIV_STEPS = DVD_W;

   localparam logic [TEX_BITS-1:0] TEX_MAX = TEX_BITS'(TEX_SIZE - 1);

   // face textures
   localparam logic [1:0] TEX_ID_NORTH = 2'd0;
   localparam logic [1:0] TEX_ID_SOUTH = 2'd1;
   localparam logic [1:0] TEX_ID_WEST  = 2'd2;
   localparam logic [1:0] TEX_ID_EAST  = 2'd3;

   // configuration registers
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MID_ROW       = CSR_IDX_W'(1);
   localparam logic [CSR_DATA_W-1:0] SCREEN_HEIGHT_RST = CSR_DATA_W'(480);
   localparam logic [CSR_DATA_W-1:0] MID_ROW_RST       = CSR_DATA_W'(240);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]          texture_id;
      logic                draw_range;
      logic [BASE_W-1:0]   base;
      logic [PROD_W-1:0]   prod;
      logic                num_neg;
      logic [MAG_W-1:0]    num_mag;
      logic [SLICE_W-1:0]  divisor;
   } front_entry_type;

endpackage

// ===== design/wtcm_req_if.sv =====
// ----------------------------------------------------------------------------
// wtcm_req_if
// Request channel: one screen row of a wall column.
// ----------------------------------------------------------------------------
interface wtcm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [wtcm_pkg::ROW_W-1:0]           row;
   logic                                 side;
   logic signed [wtcm_pkg::DIR_W-1:0]    dir_x;
   logic signed [wtcm_pkg::DIR_W-1:0]    dir_y;
   logic [wtcm_pkg::POS_W-1:0]           player_x;
   logic [wtcm_pkg::POS_W-1:0]           player_y;
   logic [wtcm_pkg::DIST_W-1:0]          wall_distance;
   logic [wtcm_pkg::CELL_W-1:0]          cell_x;
   logic [wtcm_pkg::CELL_W-1:0]          cell_y;
   logic [wtcm_pkg::SLICE_W-1:0]         slice_height;
   logic [wtcm_pkg::ROW_W-1:0]           draw_first;
   logic [wtcm_pkg::ROW_W-1:0]           draw_last;

   modport source (
      output valid, row, side, dir_x, dir_y, player_x, player_y, wall_distance,
             cell_x, cell_y, slice_height, draw_first, draw_last,
      input  ready
   );
   modport sink (
      input  valid, row, side, dir_x, dir_y, player_x, player_y, wall_distance,
             cell_x, cell_y, slice_height, draw_first, draw_last,
      output ready
   );
endinterface

// ===== design/wtcm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// wtcm_rsp_if
// Response channel: texture select and texel coordinates of one pixel.
// ----------------------------------------------------------------------------
interface wtcm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            draw_pixel;
   logic [1:0]                      texture_id;
   logic [wtcm_pkg::TEX_BITS-1:0]   texel_column;
   logic [wtcm_pkg::TEX_BITS-1:0]   texel_row;

   modport source (
      output valid, draw_pixel, texture_id, texel_column, texel_row,
      input  ready
   );
   modport sink (
      input  valid, draw_pixel, texture_id, texel_column, texel_row,
      output ready
   );
endinterface

// ===== design/wtcm_csr_if.sv =====
// ----------------------------------------------------------------------------
// wtcm_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wtcm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [wtcm_pkg::CSR_IDX_W-1:0]    index;
   logic [wtcm_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/wtcm_front.sv =====
// ----------------------------------------------------------------------------
// wtcm_front
// Takes requests, holds the configuration registers, picks the face texture,
// forms the hit product and the texel row numerator for the back end.
// ----------------------------------------------------------------------------
module wtcm_front (
   input  logic                          clock,
   input  logic                          reset,
   wtcm_req_if.sink                      req_ch,
   wtcm_csr_if.sink                      csr_ch,
   output logic                          push_valid,
   input  logic                          push_ready,
   output wtcm_pkg::front_entry_type     push_data
);

   logic [wtcm_pkg::CSR_DATA_W-1:0] screen_height_ff, screen_height_in;
   logic [wtcm_pkg::CSR_DATA_W-1:0] mid_row_ff, mid_row_in;

   logic                                 f1_valid_ff, f1_valid_in;
   logic [wtcm_pkg::ROW_W-1:0]           f1_row_ff;
   logic                                 f1_side_ff;
   logic signed [wtcm_pkg::DIR_W-1:0]    f1_dir_x_ff;
   logic signed [wtcm_pkg::DIR_W-1:0]    f1_dir_y_ff;
   logic [wtcm_pkg::POS_W-1:0]           f1_player_x_ff;
   logic [wtcm_pkg::POS_W-1:0]           f1_player_y_ff;
   logic [wtcm_pkg::DIST_W-1:0]          f1_dist_ff;
   logic [wtcm_pkg::CELL_W-1:0]          f1_cell_x_ff;
   logic [wtcm_pkg::CELL_W-1:0]          f1_cell_y_ff;
   logic [wtcm_pkg::SLICE_W-1:0]         f1_slice_ff;
   logic [wtcm_pkg::ROW_W-1:0]           f1_first_ff;
   logic [wtcm_pkg::ROW_W-1:0]           f1_last_ff;

   logic                                 req_fire;
   logic [wtcm_pkg::POS_W-1:0]           pos_sel;
   logic signed [wtcm_pkg::DIR_W-1:0]    dir_sel;
   logic [wtcm_pkg::CELL_W-1:0]          cell_sel;
   logic [wtcm_pkg::BASE_W-1:0]          pos_sh;
   logic [wtcm_pkg::BASE_W-1:0]          cell_sh;
   logic signed [wtcm_pkg::DIST_W:0]     dist_s;
   logic signed [wtcm_pkg::PROD_W:0]     prod_wide;
   logic [wtcm_pkg::SLICE_W-1:0]         slice_eff;
   logic [wtcm_pkg::NUM_W-1:0]           num;
   logic [wtcm_pkg::NUM_W-1:0]           num_abs;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_comb begin
      screen_height_in = screen_height_ff;
      mid_row_in       = mid_row_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            wtcm_pkg::CSR_SCREEN_HEIGHT: screen_height_in = csr_ch.data;
            wtcm_pkg::CSR_MID_ROW:       mid_row_in       = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff <= wtcm_pkg::SCREEN_HEIGHT_RST;
         mid_row_ff       <= wtcm_pkg::MID_ROW_RST;
      end else begin
         screen_height_ff <= screen_height_in;
         mid_row_ff       <= mid_row_in;
      end
   end

   // input register
   assign req_ch.ready = !f1_valid_ff || push_ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   always_comb begin
      f1_valid_in = f1_valid_ff;
      if (req_fire) begin
         f1_valid_in = 1'b1;
      end else if (push_ready) begin
         f1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         f1_row_ff      <= req_ch.row;
         f1_side_ff     <= req_ch.side;
         f1_dir_x_ff    <= req_ch.dir_x;
         f1_dir_y_ff    <= req_ch.dir_y;
         f1_player_x_ff <= req_ch.player_x;
         f1_player_y_ff <= req_ch.player_y;
         f1_dist_ff     <= req_ch.wall_distance;
         f1_cell_x_ff   <= req_ch.cell_x;
         f1_cell_y_ff   <= req_ch.cell_y;
         f1_slice_ff    <= req_ch.slice_height;
         f1_first_ff    <= req_ch.draw_first;
         f1_last_ff     <= req_ch.draw_last;
      end
   end

   // x-side faces sample along y, y-side faces along x
   always_comb begin
      if (f1_side_ff) begin
         pos_sel  = f1_player_x_ff;
         dir_sel  = f1_dir_x_ff;
         cell_sel = f1_cell_x_ff;
      end else begin
         pos_sel  = f1_player_y_ff;
         dir_sel  = f1_dir_y_ff;
         cell_sel = f1_cell_y_ff;
      end
   end

   assign pos_sh    = wtcm_pkg::BASE_W'(pos_sel) << wtcm_pkg::FRAC_BITS;
   assign cell_sh   = wtcm_pkg::BASE_W'(cell_sel) << (2 * wtcm_pkg::FRAC_BITS);
   assign dist_s    = {1'b0, f1_dist_ff};
   assign prod_wide = dist_s * dir_sel;

   assign slice_eff = (f1_slice_ff == '0) ? wtcm_pkg::SLICE_W'(1) : f1_slice_ff;
   assign num       = wtcm_pkg::NUM_W'(f1_row_ff) - wtcm_pkg::NUM_W'(mid_row_ff)
                      + wtcm_pkg::NUM_W'(slice_eff >> 1);
   assign num_abs   = num[wtcm_pkg::NUM_W-1] ? (wtcm_pkg::NUM_W'(0) - num) : num;

   always_comb begin
      if (f1_side_ff) begin
         push_data.texture_id = f1_dir_y_ff[wtcm_pkg::DIR_W-1] ?
                                wtcm_pkg::TEX_ID_SOUTH : wtcm_pkg::TEX_ID_NORTH;
      end else begin
         push_data.texture_id = f1_dir_x_ff[wtcm_pkg::DIR_W-1] ?
                                wtcm_pkg::TEX_ID_EAST : wtcm_pkg::TEX_ID_WEST;
      end
      push_data.draw_range = (f1_row_ff >= f1_first_ff) && (f1_row_ff < f1_last_ff)
                             && (f1_row_ff < screen_height_ff);
      push_data.base       = pos_sh - cell_sh;
      push_data.prod       = prod_wide[wtcm_pkg::PROD_W-1:0];
      push_data.num_neg    = num[wtcm_pkg::NUM_W-1];
      push_data.num_mag    = num_abs[wtcm_pkg::MAG_W-1:0];
      push_data.divisor    = slice_eff;
   end

   assign push_valid = f1_valid_ff;

endmodule

// ===== design/wtcm_queue.sv =====
// ----------------------------------------------------------------------------
// wtcm_queue
// Short transaction queue between the front and the back end.
// ----------------------------------------------------------------------------
module wtcm_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   output logic                          push_ready,
   input  wtcm_pkg::front_entry_type     push_data,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output wtcm_pkg::front_entry_type     pop_data
);

   wtcm_pkg::front_entry_type       entry_ff [wtcm_pkg::QUEUE_DEPTH];
   logic [wtcm_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [wtcm_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [wtcm_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            push_fire;
   logic                            pop_fire;

   assign push_ready = count_ff != wtcm_pkg::QCNT_W'(wtcm_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == wtcm_pkg::QPTR_W'(wtcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == wtcm_pkg::QPTR_W'(wtcm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= wtcm_pkg::QCNT_W'(wtcm_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + wtcm_pkg::QCNT_W'(1)))
      else $error("queue count did not follow a push");
`endif

endmodule

// ===== design/wtcm_back.sv =====
// ----------------------------------------------------------------------------
// wtcm_back
// Resolves the texel column from the wall hit and runs the texel row
// division one quotient bit per stage; the last stage is the output register.
// ----------------------------------------------------------------------------
module wtcm_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  wtcm_pkg::front_entry_type     pop_data,
   wtcm_rsp_if.source                    rsp_ch
);

   typedef struct packed {
      logic                             valid;
      logic [1:0]                       texture_id;
      logic                             draw_pixel;
      logic [wtcm_pkg::TEX_BITS-1:0]    texel_column;
      logic                             num_neg;
      logic [wtcm_pkg::DVD_W-1:0]       dividend;
      logic [wtcm_pkg::SLICE_W-1:0]     rem;
      logic [wtcm_pkg::SLICE_W-1:0]     divisor;
      logic [wtcm_pkg::TEX_BITS-1:0]    quo;
   } back_stage_type;

   back_stage_type                  pipe_ff [wtcm_pkg::DIV_STEPS+1];
   back_stage_type                  pipe_in [wtcm_pkg::DIV_STEPS+1];
   logic                            advance;
   logic [wtcm_pkg::HIT_W-1:0]      hit;
   logic                            hit_neg;
   logic                            col_ok;
   logic [wtcm_pkg::TEX_BITS-1:0]   col;

   // one restoring division step
   function automatic back_stage_type div_step(back_stage_type s);
      back_stage_type               n;
      logic [wtcm_pkg::SLICE_W:0]   r2;
      logic [wtcm_pkg::SLICE_W:0]   diff;
      logic                         ge;
      n    = s;
      r2   = {s.rem, s.dividend[wtcm_pkg::DVD_W-1]};
      diff = r2 - {1'b0, s.divisor};
      ge   = r2 >= {1'b0, s.divisor};
      n.rem      = ge ? diff[wtcm_pkg::SLICE_W-1:0] : r2[wtcm_pkg::SLICE_W-1:0];
      n.dividend = s.dividend << 1;
      n.quo      = {s.quo[wtcm_pkg::TEX_BITS-2:0], ge};
      return n;
   endfunction

   assign advance   = !pipe_ff[wtcm_pkg::DIV_STEPS].valid || rsp_ch.ready;
   assign pop_ready = advance;

   // wall hit in Q.2F
   assign hit = {{(wtcm_pkg::HIT_W - wtcm_pkg::BASE_W){pop_data.base[wtcm_pkg::BASE_W-1]}},
                 pop_data.base}
              + {{(wtcm_pkg::HIT_W - wtcm_pkg::PROD_W){pop_data.prod[wtcm_pkg::PROD_W-1]}},
                 pop_data.prod};
   assign hit_neg = hit[wtcm_pkg::HIT_W-1];

   // negative hits only map inside the texture when they truncate to zero
   always_comb begin
      if (hit_neg) begin
         col_ok = (&hit[wtcm_pkg::HIT_W-1:wtcm_pkg::COL_SHIFT])
                  && (|hit[wtcm_pkg::COL_SHIFT-1:0]);
         col    = wtcm_pkg::TEX_MAX;
      end else begin
         col_ok = ~|hit[wtcm_pkg::HIT_W-1:2*wtcm_pkg::FRAC_BITS];
         col    = wtcm_pkg::TEX_MAX
                  - hit[2*wtcm_pkg::FRAC_BITS-1:wtcm_pkg::COL_SHIFT];
      end
   end

   always_comb begin
      pipe_in[0].valid        = pop_valid;
      pipe_in[0].texture_id   = pop_data.texture_id;
      pipe_in[0].draw_pixel   = pop_data.draw_range && col_ok;
      pipe_in[0].texel_column = col_ok ? col : '0;
      pipe_in[0].num_neg      = pop_data.num_neg;
      pipe_in[0].dividend     = {pop_data.num_mag, wtcm_pkg::TEX_BITS'(0)};
      pipe_in[0].rem          = '0;
      pipe_in[0].divisor      = pop_data.divisor;
      pipe_in[0].quo          = '0;
      for (int k = 0; k < wtcm_pkg::DIV_STEPS; k++) begin
         pipe_in[k+1] = div_step(pipe_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= wtcm_pkg::DIV_STEPS; k++) begin
            pipe_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   assign rsp_ch.valid        = pipe_ff[wtcm_pkg::DIV_STEPS].valid;
   assign rsp_ch.draw_pixel   = pipe_ff[wtcm_pkg::DIV_STEPS].draw_pixel;
   assign rsp_ch.texture_id   = pipe_ff[wtcm_pkg::DIV_STEPS].texture_id;
   assign rsp_ch.texel_column = pipe_ff[wtcm_pkg::DIV_STEPS].texel_column;
   // quotient keeps only its low bits, so negation wraps mod texture size
   assign rsp_ch.texel_row    = pipe_ff[wtcm_pkg::DIV_STEPS].num_neg ?
                                wtcm_pkg::TEX_BITS'(0) - pipe_ff[wtcm_pkg::DIV_STEPS].quo :
                                pipe_ff[wtcm_pkg::DIV_STEPS].quo;

`ifndef SYNTH
   a_last_stage_fill: assert property (@(posedge clock) disable iff (reset)
      (advance && pipe_ff[wtcm_pkg::DIV_STEPS-1].valid)
      |=> pipe_ff[wtcm_pkg::DIV_STEPS].valid)
      else $error("transaction lost entering the output register");

   // only a valid first stage carries defined payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!advance && pipe_ff[0].valid)
      |=> pipe_ff[0].valid
          && (pipe_ff[0].texture_id == $past(pipe_ff[0].texture_id)))
      else $error("first back stage moved during a stall");
`endif

endmodule

// ===== design/wall_texel_coordinate_mapper_top.sv =====
// ----------------------------------------------------------------------------
// wall_texel_coordinate_mapper_top
// Path from request acceptance to response valid: input register, queue, hit
//   stage, 23 single-bit division stages.
// Throughput: one transaction per cycle while the response sink is ready.
// Reset: synchronous; clears valid bits, queue pointers and counts, loads
//   screen_height 480 and mid_row 240.
// ----------------------------------------------------------------------------
module wall_texel_coordinate_mapper_top (
   input  logic          clock,
   input  logic          reset,
   wtcm_req_if.sink      req_ch,
   wtcm_rsp_if.source    rsp_ch,
   wtcm_csr_if.sink      csr_ch
);

   logic                          push_valid;
   logic                          push_ready;
   wtcm_pkg::front_entry_type     push_data;
   logic                          pop_valid;
   logic                          pop_ready;
   wtcm_pkg::front_entry_type     pop_data;

   wtcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   wtcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wtcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel rows of wall columns into wall_texel_coordinate_mapper_top and
// checks texture select, texel column, texel row and draw flag of every
// response against an in-bench predictor. Directed corner cases come first,
// then register extremes, then randomized traffic with random source gaps
// and sink stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [wtcm_pkg::CSR_IDX_W-1:0] CSR_IDX_UNMAPPED = '1;
   localparam int RANDOM_PIXELS = 800;
   localparam int PHASE_PIXELS  = 160;
   localparam int PIPE_LATENCY  = 25;
   localparam int TAIL_CYCLES   = PIPE_LATENCY + 15;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [wtcm_pkg::ROW_W-1:0]          row;
      logic                                side;
      logic signed [wtcm_pkg::DIR_W-1:0]   dir_x;
      logic signed [wtcm_pkg::DIR_W-1:0]   dir_y;
      logic [wtcm_pkg::POS_W-1:0]          player_x;
      logic [wtcm_pkg::POS_W-1:0]          player_y;
      logic [wtcm_pkg::DIST_W-1:0]         wall_distance;
      logic [wtcm_pkg::CELL_W-1:0]         cell_x;
      logic [wtcm_pkg::CELL_W-1:0]         cell_y;
      logic [wtcm_pkg::SLICE_W-1:0]        slice_height;
      logic [wtcm_pkg::ROW_W-1:0]          draw_first;
      logic [wtcm_pkg::ROW_W-1:0]          draw_last;
   } wall_pixel_type;

   typedef struct {
      logic                             draw_pixel;
      logic [1:0]                       texture_id;
      logic [wtcm_pkg::TEX_BITS-1:0]    texel_column;
      logic [wtcm_pkg::TEX_BITS-1:0]    texel_row;
   } texel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wtcm_req_if req_bus ();
   wtcm_rsp_if rsp_bus ();
   wtcm_csr_if csr_bus ();

   wall_texel_coordinate_mapper_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // shadow copies of the view registers
   logic [wtcm_pkg::CSR_DATA_W-1:0] screen_rows;
   logic [wtcm_pkg::CSR_DATA_W-1:0] centre_row;

   texel_type pending_texels[$];
   int req_gap_max;
   int rsp_stall_max;
   int rsp_hold;
   int mismatches;
   int pixels_sent;
   int texels_checked;
   int reg_writes;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   // exact hit position along the wall axis, Q.32 relative to the cell
   function automatic longint wall_hit(wall_pixel_type p);
      longint pos, dir, cell_idx;
      if (p.side == 1'b0) begin
         pos      = longint'(p.player_y);
         dir      = longint'(p.dir_y);
         cell_idx = longint'(p.cell_y);
      end else begin
         pos      = longint'(p.player_x);
         dir      = longint'(p.dir_x);
         cell_idx = longint'(p.cell_x);
      end
      return (pos <<< wtcm_pkg::FRAC_BITS) + longint'(p.wall_distance) * dir
             - (cell_idx <<< (2 * wtcm_pkg::FRAC_BITS));
   endfunction

   function automatic texel_type predict_texel(wall_pixel_type p);
      texel_type t;
      longint hit, scaled, col, span, num, trow;
      bit col_ok;
      if (p.side == 1'b0) begin
         t.texture_id = p.dir_x[wtcm_pkg::DIR_W-1] ?
                        wtcm_pkg::TEX_ID_EAST : wtcm_pkg::TEX_ID_WEST;
      end else begin
         t.texture_id = p.dir_y[wtcm_pkg::DIR_W-1] ?
                        wtcm_pkg::TEX_ID_SOUTH : wtcm_pkg::TEX_ID_NORTH;
      end
      hit = wall_hit(p);
      // scale magnitude so the result truncates toward zero
      scaled = ((hit < 0 ? -hit : hit) * wtcm_pkg::TEX_SIZE) >>> (2 * wtcm_pkg::FRAC_BITS);
      if (hit < 0) begin
         scaled = -scaled;
      end
      col    = wtcm_pkg::TEX_SIZE - 1 - scaled;
      col_ok = (col >= 0) && (col < wtcm_pkg::TEX_SIZE);
      span   = (p.slice_height == '0) ? 1 : longint'(p.slice_height);
      num    = longint'(p.row) - longint'(centre_row) + span / 2;
      trow   = (num * wtcm_pkg::TEX_SIZE) / span;
      t.texel_column = col_ok ? wtcm_pkg::TEX_BITS'(col) : '0;
      t.texel_row    = wtcm_pkg::TEX_BITS'(trow);
      t.draw_pixel   = (p.row >= p.draw_first) && (p.row < p.draw_last)
                       && (p.row < screen_rows) && col_ok;
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   function automatic wall_pixel_type nominal_pixel();
      wall_pixel_type p;
      p.row           = 12'd240;
      p.side          = 1'b0;
      p.dir_x         = -19'sd65536;
      p.dir_y         = 19'sd32768;
      p.player_x      = 24'h03_8000;
      p.player_y      = 24'h02_4000;
      p.wall_distance = 24'h01_0000;
      p.cell_x        = 8'd3;
      p.cell_y        = 8'd2;
      p.slice_height  = 16'd240;
      p.draw_first    = 12'd120;
      p.draw_last     = 12'd360;
      return p;
   endfunction

   function automatic wall_pixel_type random_wall_pixel(bit aligned);
      wall_pixel_type p;
      longint cell_hit;
      logic [wtcm_pkg::CELL_W-1:0] keep;
      int unsigned lim;
      p.row           = wtcm_pkg::ROW_W'($urandom);
      p.side          = 1'($urandom);
      p.dir_x         = wtcm_pkg::DIR_W'($urandom);
      p.dir_y         = wtcm_pkg::DIR_W'($urandom);
      p.player_x      = wtcm_pkg::POS_W'($urandom);
      p.player_y      = wtcm_pkg::POS_W'($urandom);
      p.wall_distance = wtcm_pkg::DIST_W'($urandom);
      p.cell_x        = wtcm_pkg::CELL_W'($urandom);
      p.cell_y        = wtcm_pkg::CELL_W'($urandom);
      p.slice_height  = wtcm_pkg::SLICE_W'($urandom);
      p.draw_first    = wtcm_pkg::ROW_W'($urandom);
      p.draw_last     = wtcm_pkg::ROW_W'($urandom);
      if (aligned) begin
         // short distances keep the hit near the player, then pick its cell
         if ($urandom_range(0, 3) != 0) begin
            p.wall_distance = wtcm_pkg::DIST_W'($urandom_range(0, 1 << 20));
         end
         keep = p.side ? p.cell_x : p.cell_y;
         if (p.side) begin
            p.cell_x = '0;
         end else begin
            p.cell_y = '0;
         end
         cell_hit = wall_hit(p) >>> (2 * wtcm_pkg::FRAC_BITS);
         if (cell_hit < 0 || cell_hit >= (1 << wtcm_pkg::CELL_W)) begin
            cell_hit = longint'(keep);
         end
         if (p.side) begin
            p.cell_x = wtcm_pkg::CELL_W'(cell_hit);
         end else begin
            p.cell_y = wtcm_pkg::CELL_W'(cell_hit);
         end
         case ($urandom_range(0, 2))
            0: p.slice_height = wtcm_pkg::SLICE_W'($urandom_range(1, 16));
            1: p.slice_height = wtcm_pkg::SLICE_W'($urandom_range(1, 1024));
            default: ;
         endcase
         lim = screen_rows - 1;
         if ($urandom_range(0, 4) != 0) begin
            p.row = wtcm_pkg::ROW_W'($urandom_range(0, lim));
         end
         if ($urandom_range(0, 5) != 0) begin
            p.draw_first = wtcm_pkg::ROW_W'($urandom_range(0, p.row));
            p.draw_last  = wtcm_pkg::ROW_W'($urandom_range(p.row, 4095));
         end
      end
      return p;
   endfunction

   task automatic send_pixel(input wall_pixel_type p);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.row           <= p.row;
      req_bus.side          <= p.side;
      req_bus.dir_x         <= p.dir_x;
      req_bus.dir_y         <= p.dir_y;
      req_bus.player_x      <= p.player_x;
      req_bus.player_y      <= p.player_y;
      req_bus.wall_distance <= p.wall_distance;
      req_bus.cell_x        <= p.cell_x;
      req_bus.cell_y        <= p.cell_y;
      req_bus.slice_height  <= p.slice_height;
      req_bus.draw_first    <= p.draw_first;
      req_bus.draw_last     <= p.draw_last;
      do @(posedge clock); while (!req_bus.ready);
      pending_texels.push_back(predict_texel(p));
      pixels_sent++;
   endtask

   task automatic drain_texels();
      req_bus.valid <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
   endtask

   // leaves valid high; the caller drops it after its last write
   task automatic write_reg(input logic [wtcm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [wtcm_pkg::CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == wtcm_pkg::CSR_SCREEN_HEIGHT) begin
         screen_rows = value;
      end else if (idx == wtcm_pkg::CSR_MID_ROW) begin
         centre_row = value;
      end
      reg_writes++;
   endtask

   task automatic program_view(input logic [wtcm_pkg::CSR_DATA_W-1:0] rows,
                               input logic [wtcm_pkg::CSR_DATA_W-1:0] centre);
      drain_texels();
      write_reg(wtcm_pkg::CSR_SCREEN_HEIGHT, rows);
      write_reg(wtcm_pkg::CSR_MID_ROW, centre);
      csr_bus.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // response side: random stalls and checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : texel_check
      texel_type want;
      if (reset) begin
         rsp_hold = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            texels_checked++;
            if (pending_texels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("[%0t] texel transaction with nothing pending", $time);
               end
            end else begin
               want = pending_texels.pop_front();
               if (rsp_bus.draw_pixel !== want.draw_pixel ||
                   rsp_bus.texture_id !== want.texture_id ||
                   rsp_bus.texel_column !== want.texel_column ||
                   rsp_bus.texel_row !== want.texel_row) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("[%0t] exp draw/tex/col/row %0b/%0d/%0d/%0d got %0b/%0d/%0d/%0d",
                              $time, want.draw_pixel, want.texture_id,
                              want.texel_column, want.texel_row,
                              rsp_bus.draw_pixel, rsp_bus.texture_id,
                              rsp_bus.texel_column, rsp_bus.texel_row);
                  end
               end
            end
            rsp_hold = $urandom_range(0, rsp_stall_max);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      wall_pixel_type p;
      // face selection
      p = nominal_pixel();
      send_pixel(p);
      p.dir_x = '0;
      send_pixel(p);
      p = nominal_pixel();
      p.side  = 1'b1;
      p.dir_x = 19'sd16384;
      p.dir_y = -19'sd32768;
      send_pixel(p);
      p.dir_y = '0;
      send_pixel(p);
      p.dir_y = 19'sh3FFFF;
      send_pixel(p);
      p = nominal_pixel();
      p.dir_x = 19'sh40000;
      p.dir_y = 19'sh3FFFF;
      send_pixel(p);
      // every field at an extreme, then everything zero with zero slice height
      p.row = '1; p.side = 1'b1; p.dir_x = 19'sh40000; p.dir_y = 19'sh3FFFF;
      p.player_x = '1; p.player_y = '1; p.wall_distance = '1;
      p.cell_x = '1; p.cell_y = '1; p.slice_height = '1;
      p.draw_first = '0; p.draw_last = '1;
      send_pixel(p);
      p.row = '0; p.side = 1'b0; p.dir_x = '0; p.dir_y = '0;
      p.player_x = '0; p.player_y = '0; p.wall_distance = '0;
      p.cell_x = '0; p.cell_y = '0; p.slice_height = '0;
      p.draw_first = '0; p.draw_last = '0;
      send_pixel(p);
      // texel column edges: hit on the cell border, just below the next
      // border, on it, a hair below zero and clearly below zero
      p = nominal_pixel();
      p.wall_distance = '0;
      p.player_y = 24'h02_0000;
      send_pixel(p);
      p.player_y = 24'h02_FFFF;
      send_pixel(p);
      p.player_y = 24'h03_0000;
      send_pixel(p);
      p.player_y      = 24'h02_0000;
      p.wall_distance = 24'd1;
      p.dir_y         = -19'sd1;
      send_pixel(p);
      p.wall_distance = '0;
      p.player_y      = 24'h01_FC00;
      send_pixel(p);
      p = nominal_pixel();
      p.side = 1'b1; p.wall_distance = '0; p.player_x = 24'h03_FFFF;
      send_pixel(p);
      // draw range and screen bounds
      p = nominal_pixel();
      p.draw_first = 12'd300; p.draw_last = 12'd100;
      send_pixel(p);
      p = nominal_pixel();
      p.row = 12'd360;
      send_pixel(p);
      p.row = 12'd120;
      send_pixel(p);
      p.draw_last = 12'd600;
      p.row = 12'd479;
      send_pixel(p);
      p.row = 12'd480;
      send_pixel(p);
      // texel row: negative offset, unit and maximum slice
      p = nominal_pixel();
      p.row = '0; p.slice_height = 16'd16;
      send_pixel(p);
      p.slice_height = 16'd1;
      send_pixel(p);
      p.slice_height = '1;
      send_pixel(p);
   endtask

   task automatic test_register_extremes();
      wall_pixel_type p;
      program_view(12'd1, 12'd0);
      p = nominal_pixel();
      p.draw_first = '0; p.row = '0; p.slice_height = 16'd8;
      send_pixel(p);
      p.row = 12'd1;
      send_pixel(p);
      program_view(12'd4095, 12'd4095);
      p = nominal_pixel();
      p.draw_last = 12'd4095;
      p.row = 12'd4094;
      send_pixel(p);
      p.row = 12'd4095;
      send_pixel(p);
      p.row = '0; p.draw_first = '0;
      send_pixel(p);
      // a write to an unmapped index must leave both registers alone
      drain_texels();
      write_reg(CSR_IDX_UNMAPPED, '1);
      write_reg(wtcm_pkg::CSR_SCREEN_HEIGHT, wtcm_pkg::SCREEN_HEIGHT_RST);
      write_reg(wtcm_pkg::CSR_MID_ROW, '0);
      write_reg(CSR_IDX_UNMAPPED, '0);
      csr_bus.valid <= 1'b0;
      p = nominal_pixel();
      send_pixel(p);
      p.row = 12'd479; p.draw_last = 12'd600;
      send_pixel(p);
   endtask

   task automatic test_random_traffic();
      logic [wtcm_pkg::CSR_DATA_W-1:0] rows;
      logic [wtcm_pkg::CSR_DATA_W-1:0] centre;
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % PHASE_PIXELS == 0) begin
            case ($urandom_range(0, 4))
               0: rows = 12'd1;
               1: rows = 12'd4095;
               default: rows = wtcm_pkg::CSR_DATA_W'($urandom_range(200, 1200));
            endcase
            case ($urandom_range(0, 4))
               0: centre = '0;
               1: centre = 12'd4095;
               default: centre = wtcm_pkg::CSR_DATA_W'($urandom_range(0, rows));
            endcase
            program_view(rows, centre);
         end
         // stretches of back-to-back traffic between stall-heavy ones
         if (i % 50 == 0) begin
            req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
            rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         end
         send_pixel(random_wall_pixel($urandom_range(0, 3) != 0));
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.row = '0; req_bus.side = 1'b0; req_bus.dir_x = '0; req_bus.dir_y = '0;
      req_bus.player_x = '0; req_bus.player_y = '0; req_bus.wall_distance = '0;
      req_bus.cell_x = '0; req_bus.cell_y = '0; req_bus.slice_height = '0;
      req_bus.draw_first = '0; req_bus.draw_last = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      screen_rows    = wtcm_pkg::SCREEN_HEIGHT_RST;
      centre_row     = wtcm_pkg::MID_ROW_RST;
      req_gap_max    = 6;
      rsp_stall_max  = 6;
      mismatches     = 0;
      pixels_sent    = 0;
      texels_checked = 0;
      reg_writes     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_register_extremes();
      test_random_traffic();
      drain_texels();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d pixel transactions, %0d texel transactions, %0d register writes",
               pixels_sent, texels_checked, reg_writes);
      $display("directed corners, register extremes and random traffic: %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d texel transactions still pending", pending_texels.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
design/wtcm_pkg.sv
design/wtcm_req_if.sv
design/wtcm_rsp_if.sv
design/wtcm_csr_if.sv
design/wtcm_front.sv
design/wtcm_queue.sv
design/wtcm_back.sv
design/wall_texel_coordinate_mapper_top.sv
tb/sv/testbench.sv
